### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/utf8cs_pkg.sv
package utf8cs_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 3;
    localparam int PACKED_W     = 32;
    localparam int CHAR_COUNT_W = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_END_NONE = 3'd4
    } t_status;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eos;
        logic [LEN_W-1:0]  lead_len;  // 0 means not a legal lead byte
        logic              is_cont;
    } t_cls_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

### hw/rtl/utf8_char_splitter_checker.sv
// UTF-8 character splitter and checker.
// Input channel (i_valid / o_ready) takes one string byte per item, with
// i_end_of_string on the final byte. Output channel (o_valid / i_ready)
// gives at most one result per byte: the packed character bytes, their
// length, a status code, the running character count and a closing flag.
// i_cfg_we / i_cfg_strict_mode set the mode; write it only while idle.
// Throughput: one byte per cycle while the queue has room and the output
// side is not stalled, set by the state update in the back end. A byte
// accepted is queued through a two-entry buffer, then the output register,
// and its result is visible on o_valid when the output side is free.
// Bytes that give no result (inside a character, skipped) leave nothing.
// Reset (synchronous, active low) empties the queue, clears all string
// state and sets strict mode. When the receiver stalls, the output register
// holds; the queue absorbs two more bytes before o_ready drops.
`include "assert_macros.svh"

module utf8_char_splitter_checker #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_strict_mode,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [utf8cs_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                  i_end_of_string,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [utf8cs_pkg::PACKED_W-1:0]       o_packed_char,
    output logic [utf8cs_pkg::LEN_W-1:0]          o_char_len,
    output logic [utf8cs_pkg::LEN_W-1:0]          o_status,
    output logic [utf8cs_pkg::CHAR_COUNT_W-1:0]   o_char_count,
    output logic                                  o_is_last
);

    logic                    r_strict_mode;
    logic                    w_push, w_pop;
    utf8cs_pkg::t_cls_item   w_in_item, w_q_item;
    utf8cs_pkg::t_queue_stat w_qstat;
    utf8cs_pkg::t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_strict_mode <= i_cfg_strict_mode;
        end
    end

    utf8cs_front u_front (
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .i_qstat         (w_qstat),
        .o_ready         (o_ready),
        .o_push          (w_push),
        .o_item          (w_in_item)
    );

    utf8cs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_qstat)
    );

    utf8cs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_strict_mode (r_strict_mode),
        .i_item        (w_q_item),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_packed_char (o_packed_char),
        .o_char_len    (o_char_len),
        .o_status      (w_status),
        .o_char_count  (o_char_count),
        .o_is_last     (o_is_last)
    );

    assign o_status = w_status;

    // a stalled result stays put
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_packed_char), "result dropped while stalled")
    // end-without-character results are empty closers
    `ASSERT_RST(a_end_none, i_clk, i_rst_n, o_valid && w_status == utf8cs_pkg::ST_END_NONE |-> o_is_last && o_char_len == '0 && o_packed_char == '0, "bad end-without-character result")
    // a truncation always closes the string
    `ASSERT_RST(a_trunc_last, i_clk, i_rst_n, o_valid && w_status == utf8cs_pkg::ST_TRUNC |-> o_is_last && o_char_len != '0, "truncation not closing")
    // input stalls only when the queue is full
    `ASSERT_RST(a_ready_full, i_clk, i_rst_n, !o_ready |-> w_qstat.full && !w_qstat.empty, "input stalled with room in queue")

endmodule

### hw/rtl/utf8cs_front.sv
module utf8cs_front (
    input  logic                               i_valid,
    input  logic [utf8cs_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                               i_end_of_string,
    input  utf8cs_pkg::t_queue_stat            i_qstat,
    output logic                               o_ready,
    output logic                               o_push,
    output utf8cs_pkg::t_cls_item              o_item
);

    logic [utf8cs_pkg::BYTE_W-1:0] w_b;
    logic [utf8cs_pkg::LEN_W-1:0]  w_len;

    assign w_b = i_data_byte & utf8cs_pkg::BYTE_MASK;

    always_comb begin
        priority if (w_b <= 8'h7F) begin
            w_len = 3'd1;
        end else if (w_b >= 8'hC0 && w_b <= 8'hDF) begin
            w_len = 3'd2;
        end else if (w_b >= 8'hE0 && w_b <= 8'hEF) begin
            w_len = 3'd3;
        end else if (w_b >= 8'hF0 && w_b <= 8'hF7) begin
            w_len = 3'd4;
        end else begin
            w_len = 3'd0;
        end
    end

    assign o_ready          = !i_qstat.full;
    assign o_push           = i_valid && !i_qstat.full;
    assign o_item.data      = w_b;
    assign o_item.eos       = i_end_of_string;
    assign o_item.lead_len  = w_len;
    assign o_item.is_cont   = (w_b & utf8cs_pkg::CONT_MASK) == utf8cs_pkg::CONT_TAG;

endmodule

### hw/rtl/utf8cs_queue.sv
module utf8cs_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  utf8cs_pkg::t_cls_item   i_item,
    input  logic                    i_pop,
    output utf8cs_pkg::t_cls_item   o_item,
    output utf8cs_pkg::t_queue_stat o_stat
);

    localparam int DEPTH = utf8cs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8cs_pkg::t_cls_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_stat.full  = r_cnt == CNT_W'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hw/rtl/utf8cs_back.sv
module utf8cs_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_strict_mode,
    input  utf8cs_pkg::t_cls_item                 i_item,
    input  utf8cs_pkg::t_queue_stat               i_qstat,
    output logic                                  o_pop,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [utf8cs_pkg::PACKED_W-1:0]       o_packed_char,
    output logic [utf8cs_pkg::LEN_W-1:0]          o_char_len,
    output utf8cs_pkg::t_status                   o_status,
    output logic [utf8cs_pkg::CHAR_COUNT_W-1:0]   o_char_count,
    output logic                                  o_is_last
);

    localparam int PW = utf8cs_pkg::PACKED_W;
    localparam int LW = utf8cs_pkg::LEN_W;
    localparam int CW = utf8cs_pkg::CHAR_COUNT_W;
    localparam int BW = utf8cs_pkg::BYTE_W;

    // string state
    logic [LW-1:0]         r_exp_len, n_exp_len;
    logic [LW-1:0]         r_taken, n_taken;
    logic [PW-1:0]         r_accum, n_accum;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_hold, n_hold;

    // output register
    logic                  r_out_valid;
    logic [PW-1:0]         r_packed;
    logic [LW-1:0]         r_len;
    utf8cs_pkg::t_status   r_status;
    logic [CW-1:0]         r_count_out;
    logic                  r_last;

    logic                  w_emit, w_last;
    logic [PW-1:0]         w_packed;
    logic [LW-1:0]         w_len;
    utf8cs_pkg::t_status   w_status;
    logic [COUNT_BITS-1:0] w_cnt_now;
    logic [CW-1:0]         w_cnt32;
    logic [PW-1:0]         w_acc_next;
    logic [LW-1:0]         w_taken_next;
    logic                  w_inc;

    assign o_pop = !i_qstat.empty && (!r_out_valid || i_ready);

    assign w_acc_next   = {r_accum[PW-BW-1:0], i_item.data};
    assign w_taken_next = r_taken + 1'b1;

    always_comb begin
        n_exp_len = r_exp_len;
        n_taken   = r_taken;
        n_accum   = r_accum;
        n_hold    = r_hold;
        w_emit    = 1'b0;
        w_last    = i_item.eos;
        w_packed  = '0;
        w_len     = '0;
        w_status  = utf8cs_pkg::ST_OK;
        w_inc     = 1'b0;
        if (r_hold) begin
            if (i_item.eos) begin
                w_emit   = 1'b1;
                w_status = utf8cs_pkg::ST_END_NONE;
            end
        end else if (r_exp_len == '0) begin
            if (i_item.lead_len == '0) begin
                if (i_strict_mode) begin
                    n_hold   = !i_item.eos;
                    w_emit   = 1'b1;
                    w_packed = PW'(i_item.data);
                    w_len    = LW'(1);
                    w_status = utf8cs_pkg::ST_BAD_LEAD;
                end else if (i_item.eos) begin
                    w_emit   = 1'b1;
                    w_status = utf8cs_pkg::ST_END_NONE;
                end
            end else if (i_item.lead_len == LW'(1)) begin
                w_inc    = 1'b1;
                w_emit   = 1'b1;
                w_packed = PW'(i_item.data);
                w_len    = LW'(1);
            end else begin
                n_exp_len = i_item.lead_len;
                n_taken   = LW'(1);
                n_accum   = PW'(i_item.data);
                if (i_item.eos) begin
                    w_emit   = 1'b1;
                    w_packed = PW'(i_item.data);
                    w_len    = LW'(1);
                    w_status = utf8cs_pkg::ST_TRUNC;
                end
            end
        end else begin
            if (i_strict_mode && !i_item.is_cont) begin
                n_exp_len = '0;
                n_taken   = '0;
                n_accum   = '0;
                n_hold    = !i_item.eos;
                w_emit    = 1'b1;
                w_packed  = w_acc_next;
                w_len     = w_taken_next;
                w_status  = utf8cs_pkg::ST_BAD_CONT;
            end else if (w_taken_next >= r_exp_len) begin
                n_exp_len = '0;
                n_taken   = '0;
                n_accum   = '0;
                w_inc     = 1'b1;
                w_emit    = 1'b1;
                w_packed  = w_acc_next;
                w_len     = r_exp_len;
            end else begin
                n_accum = w_acc_next;
                n_taken = w_taken_next;
                if (i_item.eos) begin
                    w_emit   = 1'b1;
                    w_packed = w_acc_next;
                    w_len    = w_taken_next;
                    w_status = utf8cs_pkg::ST_TRUNC;
                end
            end
        end

        w_cnt_now = (w_inc && r_count != '1) ? r_count + 1'b1 : r_count;
        n_count   = w_cnt_now;
        // a closing result wipes the whole string context
        if (w_emit && w_last) begin
            n_exp_len = '0;
            n_taken   = '0;
            n_accum   = '0;
            n_hold    = 1'b0;
            n_count   = '0;
        end
    end

    generate
        if (COUNT_BITS > CW) begin : g_sat
            assign w_cnt32 = (|w_cnt_now[COUNT_BITS-1:CW]) ? '1 : w_cnt_now[CW-1:0];
        end else begin : g_ext
            assign w_cnt32 = CW'(w_cnt_now);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len   <= '0;
            r_taken     <= '0;
            r_accum     <= '0;
            r_count     <= '0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_exp_len <= n_exp_len;
                r_taken   <= n_taken;
                r_accum   <= n_accum;
                r_count   <= n_count;
                r_hold    <= n_hold;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_packed    <= w_packed;
            r_len       <= w_len;
            r_status    <= w_status;
            r_count_out <= w_cnt32;
            r_last      <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_char = r_packed;
    assign o_char_len    = r_len;
    assign o_status      = r_status;
    assign o_char_count  = r_count_out;
    assign o_is_last     = r_last;

endmodule
